>>> rtl/core/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    // Request codes
    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } t_op;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Controller states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_HOLD = 1'b1
    } t_state;

    // Command from controller to datapath
    typedef struct packed {
        logic exec;
    } t_dp_cmd;

endpackage

>>> rtl/core/spq_if.sv
// ----------------------------------------------------------------------------
// spq_if
// Valid/ready channels for queue requests and queue results.
// ----------------------------------------------------------------------------
interface spq_req_if #(
    parameter int PRIO_WIDTH = 16,
    parameter int DATA_WIDTH = 16
) ();
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic signed [PRIO_WIDTH-1:0] priority_req;
    logic        [DATA_WIDTH-1:0] payload;

    modport source (output valid, output req_type, output priority_req,
                    output payload, input ready);
    modport sink   (input valid, input req_type, input priority_req,
                    input payload, output ready);
endinterface

interface spq_rsp_if #(
    parameter int PRIO_WIDTH = 16,
    parameter int DATA_WIDTH = 16,
    parameter int CNT_WIDTH  = 5
) ();
    logic                         valid;
    logic                         ready;
    logic                  [1:0]  status;
    logic signed [PRIO_WIDTH-1:0] out_priority;
    logic        [DATA_WIDTH-1:0] out_payload;
    logic        [CNT_WIDTH-1:0]  entry_count;

    modport source (output valid, output status, output out_priority,
                    output out_payload, output entry_count, input ready);
    modport sink   (input valid, input status, input out_priority,
                    input out_payload, input entry_count, output ready);
endinterface

>>> rtl/core/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Handshake controller: take one request, hold its result until transfer.
// ----------------------------------------------------------------------------
module spq_ctrl
    import spq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_ready,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold ready low while reset is applied so no request transfers then.
    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd.exec  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_HOLD;
                end
            end
            S_HOLD: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/spq_datapath.sv
// ----------------------------------------------------------------------------
// spq_datapath
// Sorted slot register file with per-slot compare, plus result registers.
// ----------------------------------------------------------------------------
module spq_datapath
    import spq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int PRIO_WIDTH = 16,
    parameter int DATA_WIDTH = 16,
    parameter int CNT_WIDTH  = 5
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_dp_cmd                      i_cmd,
    input  logic                         i_req_type,
    input  logic signed [PRIO_WIDTH-1:0] i_prio,
    input  logic        [DATA_WIDTH-1:0] i_data,
    output logic                  [1:0]  o_status,
    output logic signed [PRIO_WIDTH-1:0] o_prio,
    output logic        [DATA_WIDTH-1:0] o_data,
    output logic        [CNT_WIDTH-1:0]  o_count
);

    logic signed [PRIO_WIDTH-1:0] r_prio [DEPTH];
    logic        [DATA_WIDTH-1:0] r_data [DEPTH];
    logic        [CNT_WIDTH-1:0]  r_count;
    logic                  [1:0]  r_status;
    logic signed [PRIO_WIDTH-1:0] r_oprio;
    logic        [DATA_WIDTH-1:0] r_odata;

    logic                         w_ge       [DEPTH];
    logic signed [PRIO_WIDTH-1:0] w_ins_prio [DEPTH];
    logic        [DATA_WIDTH-1:0] w_ins_data [DEPTH];
    logic signed [PRIO_WIDTH-1:0] w_del_prio [DEPTH];
    logic        [DATA_WIDTH-1:0] w_del_data [DEPTH];

    logic full;
    logic empty;
    logic is_insert;

    assign full      = (r_count == CNT_WIDTH'(DEPTH));
    assign empty     = (r_count == '0);
    assign is_insert = (i_req_type == OP_INSERT);

    // Each slot decides locally: hold, take the new entry, or take its neighbor.
    for (genvar g = 0; g < DEPTH; g++) begin : g_slot
        assign w_ge[g] = (CNT_WIDTH'(g) < r_count) && (i_prio < r_prio[g]);

        if (g == 0) begin : g_first
            assign w_ins_prio[g] = w_ge[g] ? r_prio[g] : i_prio;
            assign w_ins_data[g] = w_ge[g] ? r_data[g] : i_data;
        end else begin : g_rest
            assign w_ins_prio[g] = w_ge[g]   ? r_prio[g]
                                 : w_ge[g-1] ? i_prio : r_prio[g-1];
            assign w_ins_data[g] = w_ge[g]   ? r_data[g]
                                 : w_ge[g-1] ? i_data : r_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_del_prio[g] = r_prio[g];
            assign w_del_data[g] = r_data[g];
        end else begin : g_mid
            assign w_del_prio[g] = r_prio[g+1];
            assign w_del_data[g] = r_data[g+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (is_insert && !full) begin
                r_prio <= w_ins_prio;
                r_data <= w_ins_data;
            end else if (!is_insert && !empty) begin
                r_prio <= w_del_prio;
                r_data <= w_del_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            if (is_insert && !full) begin
                r_count <= r_count + CNT_WIDTH'(1);
            end else if (!is_insert && !empty) begin
                r_count <= r_count - CNT_WIDTH'(1);
            end
        end
    end

    // Result: head after insert, removed head on delete, zeros on a delete when empty.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (is_insert) begin
                r_status <= full ? ST_FULL : ST_OK;
                if (full || w_ge[0]) begin
                    r_oprio <= r_prio[0];
                    r_odata <= r_data[0];
                end else begin
                    r_oprio <= i_prio;
                    r_odata <= i_data;
                end
            end else if (empty) begin
                r_status <= ST_EMPTY;
                r_oprio  <= '0;
                r_odata  <= '0;
            end else begin
                r_status <= ST_OK;
                r_oprio  <= r_prio[0];
                r_odata  <= r_data[0];
            end
        end
    end

    assign o_status = r_status;
    assign o_prio   = r_oprio;
    assign o_data   = r_odata;
    assign o_count  = r_count;

endmodule

>>> rtl/core/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept sorted by descending priority.
// ----------------------------------------------------------------------------
// A request transfers in the idle cycle and the queue updates at that edge,
// then the result is held in the output register until it transfers, and
// only after that is a new request taken. The sorted slots are registers,
// every slot compares itself against the new priority in parallel, so an
// insert or delete completes at the edge on which its request transfers
// whatever the fill level. An insert lands ahead of all entries of equal or
// lower priority (newest first among equals) and returns the head after the
// insert; a delete returns the removed head. Insert into a full queue leaves
// it unchanged, reports status full and returns the current head. Delete on an
// empty queue reports status empty with zero priority and payload. The
// entry count after the request comes with every result. No clearing pass
// after reset: slots beyond the count are never read.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int PRIO_WIDTH = 16,
    parameter int DATA_WIDTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    spq_req_if.sink    i_req,
    spq_rsp_if.source  o_rsp
);

    localparam int CNT_WIDTH = $clog2(DEPTH + 1);

    t_dp_cmd cmd;

    // Controller: owns both handshakes and tells the datapath when to act.
    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_rsp.ready),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .o_cmd       (cmd)
    );

    // Datapath: sorted slots, entry count and the registered result.
    spq_datapath #(
        .DEPTH      (DEPTH),
        .PRIO_WIDTH (PRIO_WIDTH),
        .DATA_WIDTH (DATA_WIDTH),
        .CNT_WIDTH  (CNT_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_req_type (i_req.req_type),
        .i_prio     (i_req.priority_req),
        .i_data     (i_req.payload),
        .o_status   (o_rsp.status),
        .o_prio     (o_rsp.out_priority),
        .o_data     (o_rsp.out_payload),
        .o_count    (o_rsp.entry_count)
    );

`ifndef SYNTHESIS
    // Count never runs past the slot store.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.entry_count <= CNT_WIDTH'(DEPTH)))
        else $error("entry count exceeds depth");

    // A full rejection only happens with every slot in use.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == ST_FULL)
            |-> (o_rsp.entry_count == CNT_WIDTH'(DEPTH)))
        else $error("full status with free slots");

    // An accepted request shows its result on the next cycle.
    a_req_to_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> o_rsp.valid)
        else $error("result missing after request transfer");

    // No new request while a result is pending.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !i_req.ready)
        else $error("request taken while result pending");
`endif

endmodule
